### hdl/mbsh_pkg.sv
// Shared constants and helpers for the MD5 byte stream hash.
// Holds the chaining start values, round add table, rotate amounts and word order.
// No dependencies.
package mbsh_pkg;

	localparam int unsigned BlockWords = 16;
	localparam int unsigned Rounds     = 64;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	// first byte position that leaves no room for the length field
	localparam logic [5:0] LEN_POS  = 6'd56;

	localparam logic [31:0] ROUND_ADD [Rounds] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] ROUND_ROT [16] = '{
		5'd7,  5'd12, 5'd17, 5'd22,
		5'd5,  5'd9,  5'd14, 5'd20,
		5'd4,  5'd11, 5'd16, 5'd23,
		5'd6,  5'd10, 5'd15, 5'd21
	};

	// rotate amount of round r
	function automatic logic [4:0] rot_amt(input logic [5:0] r);
		return ROUND_ROT[{r[5:4], r[1:0]}];
	endfunction

	// message word used in round r
	function automatic logic [3:0] word_sel(input logic [5:0] r);
		logic [3:0] lo;
		logic [3:0] g;
		lo = r[3:0];
		unique case (r[5:4])
			2'd0: g = lo;
			2'd1: g = 4'(lo * 4'd5 + 4'd1);
			2'd2: g = 4'(lo * 4'd3 + 4'd5);
			default: g = 4'(lo * 4'd7);
		endcase
		return g;
	endfunction

	function automatic logic [31:0] bswap32(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

### hdl/md5_byte_stream_hash.sv
// MD5 digest over a byte stream: buffer, padding sequencer and one-round-per-cycle core.
// Depends on mbsh_pkg for the round tables and chaining start values.
//
//  channel | dir | payload                                         | accepted when
//  s_*     | in  | tdata[7:0] data_byte, tuser has_byte,           | s_tvalid & s_tready
//          |     | tlast end_of_message                            |
//  m_*     | out | tdata[63:0] digest_head, [127:64] digest_tail   | m_tvalid & m_tready
//
// Byte transfers are accepted while the 64-byte block fills. A full block
// holds s_tready low for one word prefetch, 64 rounds through the single round
// unit and one chaining add. Finishing a message sweeps the 16 block words to
// write pad and length, compresses once or twice, and loads the digest register
// once it is free. The digest register lets byte transfers of the next message
// proceed while the result waits; a second digest stalls until it is taken.
// arst_n clears control state and loads the chaining start values.
module md5_byte_stream_hash (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tuser,   // [0] has_byte
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata    // [63:0] digest_head, [127:64] digest_tail
);
	import mbsh_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,   // take byte transfers
		S_PAD,    // sweep block words with pad, zero fill and length
		S_LOAD,   // prefetch first message word, load working words
		S_ROUND,  // one MD5 round per cycle
		S_ADD,    // fold working words into chaining words
		S_EMIT    // move digest into output register
	} state_t;

	state_t      state_q;
	logic [31:0] ch_a_q, ch_b_q, ch_c_q, ch_d_q;   // chaining words
	logic [31:0] wa_q, wb_q, wc_q, wd_q;           // working words
	logic [63:0] total_q;                          // message byte count
	logic [5:0]  rnd_q;
	logic [3:0]  wi_q;                             // pad sweep word index
	logic        fin_q;                            // message end seen
	logic        dig_q;                            // block being compressed holds length
	logic        second_q;                         // pad block with no message bytes
	logic        m_tvalid_q;
	logic [127:0] m_tdata_q;

	// block buffer: 16 words, byte lanes little-endian
	logic [31:0] blk_mem [BlockWords];
	logic [31:0] rd_q;
	logic [3:0]  rd_addr;
	logic        wr_en;
	logic [3:0]  wr_addr;
	logic [3:0]  wr_be;
	logic [31:0] wr_data;

	logic [5:0]  pos;
	logic        accept;
	logic        len_blk;
	logic [63:0] bit_len;
	logic        emit_go;

	assign pos      = total_q[5:0];
	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign len_blk  = second_q || (pos < LEN_POS);
	assign bit_len  = {total_q[60:0], 3'b000};
	assign emit_go  = (state_q == S_EMIT) && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// write port: single bytes while collecting, one word at a time while padding, message bytes kept
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos[5:2];
		wr_be   = 4'b0000;
		wr_data = {4{s_tdata}};
		if (state_q == S_IDLE) begin
			wr_en = accept && s_tuser;
			wr_be = 4'(4'b0001 << pos[1:0]);
		end else if (state_q == S_PAD) begin
			wr_en   = 1'b1;
			wr_addr = wi_q;
			for (int k = 0; k < 4; k++) begin
				if (second_q || ({wi_q, 2'(k)} > pos)) begin
					wr_be[k]           = 1'b1;
					wr_data[8*k +: 8]  = 8'h00;
				end else if ({wi_q, 2'(k)} == pos) begin
					wr_be[k]           = 1'b1;
					wr_data[8*k +: 8]  = PAD_BYTE;
				end else begin
					wr_be[k]           = 1'b0;
					wr_data[8*k +: 8]  = 8'h00;
				end
			end
			if (len_blk && wi_q == 4'd14) begin
				wr_be   = 4'b1111;
				wr_data = bit_len[31:0];
			end else if (len_blk && wi_q == 4'd15) begin
				wr_be   = 4'b1111;
				wr_data = bit_len[63:32];
			end
		end
	end

	// read address runs one round ahead of the round unit
	always_comb begin
		if (state_q == S_ROUND) begin
			rd_addr = word_sel(6'(rnd_q + 6'd1));
		end else begin
			rd_addr = word_sel(6'd0);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			if (wr_en && wr_be[k]) begin
				blk_mem[wr_addr][8*k +: 8] <= wr_data[8*k +: 8];
			end
		end
		rd_q <= blk_mem[rd_addr];
	end

	// round unit
	logic [31:0] f_val;
	logic [31:0] sum;
	logic [31:0] rot;
	logic [4:0]  sh;

	always_comb begin
		unique case (rnd_q[5:4])
			2'd0: f_val = (wb_q & wc_q) | (~wb_q & wd_q);
			2'd1: f_val = (wd_q & wb_q) | (~wd_q & wc_q);
			2'd2: f_val = wb_q ^ wc_q ^ wd_q;
			default: f_val = wc_q ^ (wb_q | ~wd_q);
		endcase
		sum = wa_q + f_val + ROUND_ADD[rnd_q] + rd_q;
		sh  = rot_amt(rnd_q);
		rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ch_a_q     <= IV_A;
			ch_b_q     <= IV_B;
			ch_c_q     <= IV_C;
			ch_d_q     <= IV_D;
			total_q    <= '0;
			rnd_q      <= '0;
			wi_q       <= '0;
			fin_q      <= 1'b0;
			dig_q      <= 1'b0;
			second_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// raise valid on a digest load, drop it once the result is taken
			if (emit_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						fin_q <= s_tlast;
						if (s_tuser) begin
							total_q <= total_q + 64'd1;
						end
						if (s_tuser && pos == 6'd63) begin
							state_q <= S_LOAD;
						end else if (s_tlast) begin
							wi_q    <= '0;
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					wi_q <= wi_q + 4'd1;
					if (wi_q == 4'd15) begin
						dig_q    <= len_blk;
						second_q <= !len_blk;
						state_q  <= S_LOAD;
					end
				end
				S_LOAD: begin
					wa_q    <= ch_a_q;
					wb_q    <= ch_b_q;
					wc_q    <= ch_c_q;
					wd_q    <= ch_d_q;
					rnd_q   <= '0;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					wa_q  <= wd_q;
					wb_q  <= wb_q + rot;
					wc_q  <= wb_q;
					wd_q  <= wc_q;
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'(Rounds - 1)) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					ch_a_q <= ch_a_q + wa_q;
					ch_b_q <= ch_b_q + wb_q;
					ch_c_q <= ch_c_q + wc_q;
					ch_d_q <= ch_d_q + wd_q;
					if (dig_q) begin
						state_q <= S_EMIT;
					end else if (fin_q) begin
						wi_q    <= '0;
						state_q <= S_PAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					// hold until the output register is free
					if (emit_go) begin
						m_tdata_q  <= {bswap32(ch_c_q), bswap32(ch_d_q),
						               bswap32(ch_a_q), bswap32(ch_b_q)};
						ch_a_q     <= IV_A;
						ch_b_q     <= IV_B;
						ch_c_q     <= IV_C;
						ch_d_q     <= IV_D;
						total_q    <= '0;
						fin_q      <= 1'b0;
						dig_q      <= 1'b0;
						second_q   <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### test/testbench.sv
// Self-checking testbench for md5_byte_stream_hash: byte-stream messages in, 128-bit digests out.
// Predicts every digest with a local MD5 model and compares each result with the oldest one owed.
// Depends only on the md5_byte_stream_hash module.
module testbench;

	// Per-round additive constants and rotate amounts of MD5 (RFC 1321)
	localparam logic [31:0] ADD_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};
	localparam int SHIFT_AMT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

	localparam int ITEM_TARGET   = 1450;  // byte-carrying or end-marking transfers to send
	localparam int HOLDOFF_LEN   = 600;   // cycles the receiver refuses digests under pressure
	localparam int SETTLE_CYCLES = 300;   // covers a finish sweep plus two compressions

	typedef struct packed {
		logic [63:0] head;
		logic [63:0] tail;
	} digest_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;   // [7:0] data_byte
	logic         s_tuser;   // [0] has_byte
	logic         s_tlast;   // end_of_message
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;   // [63:0] digest_head, [127:64] digest_tail

	// Local MD5 state: chaining words, current block and running byte count
	logic [31:0] chain [4];
	logic [7:0]  blk [64];
	logic [63:0] msg_bytes;

	digest_t     digests_owed [$];

	int  items_sent;
	int  msgs_sent;
	int  digests_checked;
	int  errors;
	bit  gaps_on;
	bit  stalls_on;
	int  hold_left;
	int  stall_left;

	md5_byte_stream_hash dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: far above the slowest legal run of this stimulus
	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	//------------------------------------------------------------------
	// Digest predictor
	//------------------------------------------------------------------

	function automatic void md5_start();
		chain[0]  = 32'h67452301;
		chain[1]  = 32'hefcdab89;
		chain[2]  = 32'h98badcfe;
		chain[3]  = 32'h10325476;
		msg_bytes = '0;
	endfunction

	// Run the 64 rounds over blk and fold the result into the chaining words
	function automatic void md5_compress();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, f, t, x;
		int g, s;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		for (int r = 0; r < 64; r++) begin
			case (r / 16)
				0: begin
					f = (b & c) | (~b & d);
					g = r;
				end
				1: begin
					f = (d & b) | (~d & c);
					g = (5 * r + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * r + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * r) % 16;
				end
			endcase
			s = SHIFT_AMT[(r / 16) * 4 + r % 4];
			x = a + f + ADD_K[r] + w[g];
			t = d;
			d = c;
			c = b;
			b = b + ((x << s) | (x >> (32 - s)));
			a = t;
		end
		chain[0] += a;
		chain[1] += b;
		chain[2] += c;
		chain[3] += d;
	endfunction

	// Take one message byte; a completed block is compressed at once
	function automatic void md5_absorb(input logic [7:0] data);
		int pos;
		pos = int'(msg_bytes[5:0]);
		blk[pos] = data;
		msg_bytes += 64'd1;
		if (pos == 63)
			md5_compress();
	endfunction

	// Pad, append the bit length, compress and hand back the digest; restart the chain
	function automatic digest_t md5_finish();
		digest_t     dg;
		logic [63:0] bit_len;
		logic [7:0]  byte_val;
		int pos;
		pos     = int'(msg_bytes[5:0]);
		bit_len = msg_bytes << 3;
		blk[pos] = 8'h80;
		pos++;
		// no room left for the length field: close this block with zeros first
		if (pos > 56) begin
			for (; pos < 64; pos++)
				blk[pos] = 8'h00;
			md5_compress();
			pos = 0;
		end
		for (; pos < 56; pos++)
			blk[pos] = 8'h00;
		for (int i = 0; i < 8; i++)
			blk[56 + i] = bit_len[8*i +: 8];
		md5_compress();
		dg = '0;
		// digest byte k is byte k%4 of chaining word k/4; byte 0 goes on top
		for (int k = 0; k < 16; k++) begin
			byte_val = chain[k / 4][8 * (k % 4) +: 8];
			if (k < 8)
				dg.head = {dg.head[55:0], byte_val};
			else
				dg.tail = {dg.tail[55:0], byte_val};
		end
		md5_start();
		return dg;
	endfunction

	//------------------------------------------------------------------
	// Input side
	//------------------------------------------------------------------

	// Offer one item after a random gap, hold it until the transfer, then predict
	task automatic send_item(input logic [7:0] data, input logic has_byte, input logic eom);
		int gap;
		gap = gaps_on ? $urandom_range(0, 4) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= has_byte;
		s_tlast  <= eom;
		do @(posedge clk); while (!s_tready);
		if (has_byte || eom)
			items_sent++;
		if (has_byte)
			md5_absorb(data);
		if (eom) begin
			digests_owed.push_back(md5_finish());
			msgs_sent++;
		end
	endtask

	// One message of len bytes with the odd ignored item mixed in; close it either
	// on the last byte or with a separate byte-less end transfer
	task automatic send_message(input int len, input bit end_on_byte);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
		end
		if (!end_on_byte || len == 0)
			send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	// Mostly short messages; a good share sits around the padding and block edges
	function automatic int pick_length();
		int edges [12] = '{54, 55, 56, 57, 63, 64, 65, 119, 120, 121, 127, 128};
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return $urandom_range(0, 16);
		else if (roll < 80)
			return edges[$urandom_range(0, 11)];
		else
			return $urandom_range(17, 200);
	endfunction

	//------------------------------------------------------------------
	// Output side
	//------------------------------------------------------------------

	// Receiver: refuse during a hold-off, else after each digest wait a drawn stall
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Check each digest transfer against the oldest prediction
	always @(posedge clk) begin
		digest_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (digests_owed.size() == 0) begin
				$error("digest %h arrived with none outstanding", m_tdata);
				errors++;
			end else begin
				want = digests_owed.pop_front();
				if (m_tdata[63:0] !== want.head) begin
					$error("digest_head: expected %h, got %h", want.head, m_tdata[63:0]);
					errors++;
				end
				if (m_tdata[127:64] !== want.tail) begin
					$error("digest_tail: expected %h, got %h", want.tail, m_tdata[127:64]);
					errors++;
				end
			end
			digests_checked++;
			stall_left = stalls_on ? $urandom_range(0, 4) : 0;
		end
	end

	//------------------------------------------------------------------
	// Tests
	//------------------------------------------------------------------

	// Empty messages, byte extremes, ignored items and both ways to end a message
	task automatic test_directed();
		send_item(8'hA5, 1'b0, 1'b1);          // empty message
		send_item(8'hFF, 1'b0, 1'b0);          // ignored item
		send_item(8'h00, 1'b0, 1'b1);          // another empty message, after the ignored item
		send_item(8'h00, 1'b1, 1'b1);          // single zero byte, end on the byte
		send_item(8'hFF, 1'b1, 1'b1);          // single all-ones byte
		send_item(8'h80, 1'b1, 1'b0);
		send_item(8'h7F, 1'b1, 1'b1);
		send_item(8'h61, 1'b1, 1'b0);          // "abc" with an ignored item inside
		send_item(8'h5A, 1'b0, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b0);
		send_item(8'hFF, 1'b0, 1'b1);          // separate end without a byte
	endtask

	// Full-rate stretch: no source gaps, no sink stalls
	task automatic test_back_to_back(input int count);
		int stop_at;
		stop_at   = items_sent + count;
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		while (items_sent < stop_at)
			send_message(pick_length(), 1'($urandom_range(0, 1)));
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
	endtask

	// Hold the sink off long enough that both digest slots fill and input stalls
	task automatic test_sink_holdoff();
		hold_left = HOLDOFF_LEN;
		repeat (6)
			send_message($urandom_range(0, 12), 1'($urandom_range(0, 1)));
	endtask

	task automatic test_random_messages(input int target);
		while (items_sent < target)
			send_message(pick_length(), 1'($urandom_range(0, 1)));
	endtask

	initial begin
		arst_n          = 1'b0;
		s_tvalid        = 1'b0;
		s_tdata         = 8'h00;
		s_tuser         = 1'b0;
		s_tlast         = 1'b0;
		items_sent      = 0;
		msgs_sent       = 0;
		digests_checked = 0;
		errors          = 0;
		gaps_on         = 1'b1;
		stalls_on       = 1'b1;
		hold_left       = 0;
		stall_left      = 0;
		md5_start();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_back_to_back(150);
		test_sink_holdoff();
		test_random_messages(ITEM_TARGET);

		// drop valid and let every owed digest drain
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (digests_owed.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Hashed %0d messages from %0d data/end transfers; %0d digests compared.",
			msgs_sent, items_sent, digests_checked);
		$display("Covered empty and padding-edge lengths, ignored items, full rate and sink hold-off.");
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
